### rtl/core/utcl_pkg.sv
// types and constants shared by the utc to local date pipeline
package utcl_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int Q100_W  = 8;
    localparam int SUM_W   = 15;
    localparam int Q7_W    = 12;

    // reciprocal constants for division by 100 and by 7
    localparam int DIV100_MUL   = 10486;
    localparam int DIV100_SHIFT = 20;
    localparam int DIV7_MUL     = 18725;
    localparam int DIV7_SHIFT   = 17;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [HOUR_W-1:0]  DST_HOUR  = 5'd1;

    typedef struct packed {
        logic [YEAR_W-1:0]  utc_year;
        logic [MONTH_W-1:0] utc_month;
        logic [DAY_W-1:0]   utc_day;
        logic [HOUR_W-1:0]  utc_hour;
    } t_utc_word;

    typedef struct packed {
        logic [YEAR_W-1:0]  local_year;
        logic [MONTH_W-1:0] local_month;
        logic [DAY_W-1:0]   local_day;
        logic [HOUR_W-1:0]  local_hour;
        logic               summer_time;
    } t_local_word;

    typedef struct packed {
        logic               valid;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [HOUR_W-1:0]  hour_red;
        logic               carry;
        logic               leap;
        logic [SUM_W-1:0]   sum_mar;
        logic [SUM_W-1:0]   sum_oct;
    } t_s2;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } t_date;

endpackage

### rtl/core/utcl_front.sv
// stages one and two: hour sum, year division by 100, leap year and weekday sums
module utcl_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  utcl_pkg::t_utc_word i_word,
    input  logic [4:0]          i_hour_offset,
    output utcl_pkg::t_s2       o_s2
);
    import utcl_pkg::*;

    logic                  r_v1;
    logic [YEAR_W-1:0]     r_y1;
    logic [MONTH_W-1:0]    r_m1;
    logic [DAY_W-1:0]      r_d1;
    logic [HOUR_W-1:0]     r_h1;
    logic [HOUR_W-1:0]     r_hr1;
    logic                  r_cy1;
    logic [Q100_W-1:0]     r_q1;

    logic [HOUR_W:0]       n_lh;
    logic [HOUR_W-1:0]     n_hr;
    logic [27:0]           n_prod;

    logic [YEAR_W-1:0]     n_r100;
    logic                  n_leap;
    logic [SUM_W-1:0]      n_sum;
    t_s2                   r_s2;
    t_s2                   n_s2;

    always_comb begin
        n_lh   = {1'b0, i_word.utc_hour} + {1'b0, i_hour_offset};
        n_prod = 28'(i_word.utc_year) * 28'(DIV100_MUL);
        if (n_lh >= 6'd48) begin
            n_hr = HOUR_W'(n_lh - 6'd48);
        end else if (n_lh >= 6'd24) begin
            n_hr = HOUR_W'(n_lh - 6'd24);
        end else begin
            n_hr = HOUR_W'(n_lh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y1  <= i_word.utc_year;
        r_m1  <= i_word.utc_month;
        r_d1  <= i_word.utc_day;
        r_h1  <= i_word.utc_hour;
        r_hr1 <= n_hr;
        r_cy1 <= (n_lh > 6'd23);
        r_q1  <= n_prod[DIV100_SHIFT +: Q100_W];
    end

    always_comb begin
        n_r100 = r_y1 - YEAR_W'(r_q1) * YEAR_W'(100);
        n_leap = (r_y1[1:0] == 2'b00) && ((n_r100 != '0) || (r_q1[1:0] == 2'b00));
        n_sum  = SUM_W'(r_y1) + SUM_W'(r_y1 >> 2) - SUM_W'(r_q1) + SUM_W'(r_q1 >> 2);
        n_s2.valid    = r_v1;
        n_s2.year     = r_y1;
        n_s2.month    = r_m1;
        n_s2.day      = r_d1;
        n_s2.hour     = r_h1;
        n_s2.hour_red = r_hr1;
        n_s2.carry    = r_cy1;
        n_s2.leap     = n_leap;
        n_s2.sum_mar  = n_sum + SUM_W'(5);
        n_s2.sum_oct  = n_sum + SUM_W'(2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

### rtl/core/utcl_date.sv
// stage three: day, month and year carry
module utcl_date (
    input  logic            i_clk,
    input  utcl_pkg::t_s2   i_s2,
    output utcl_pkg::t_date o_date
);
    import utcl_pkg::*;

    logic [DAY_W:0]   n_len;
    logic [DAY_W:0]   n_dn;
    logic [MONTH_W:0] n_mn;
    t_date            n_date;
    t_date            r_date;

    always_comb begin
        unique case (i_s2.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n_len = 6'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n_len = 6'd30;
            default:                                   n_len = i_s2.leap ? 6'd29 : 6'd28;
        endcase
        n_dn = {1'b0, i_s2.day} + 6'd1;
        n_mn = {1'b0, i_s2.month} + 5'd1;

        n_date.year  = i_s2.year;
        n_date.month = i_s2.month;
        n_date.day   = i_s2.day;
        n_date.hour  = i_s2.hour_red;
        if (i_s2.carry) begin
            if (n_dn > n_len) begin
                n_date.day = DAY_W'(1);
                if (n_mn > {1'b0, MONTH_DEC}) begin
                    n_date.month = MONTH_JAN;
                    n_date.year  = i_s2.year + YEAR_W'(1);
                end else begin
                    n_date.month = MONTH_W'(n_mn);
                end
            end else begin
                n_date.day = DAY_W'(n_dn);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
    end

    assign o_date = r_date;

endmodule

### rtl/core/utcl_dst.sv
// stage three and four: weekday of the last days of march and october, summer flag
module utcl_dst (
    input  logic          i_clk,
    input  utcl_pkg::t_s2 i_s2,
    output logic          o_summer
);
    import utcl_pkg::*;

    logic [29:0]        n_pm;
    logic [29:0]        n_po;
    logic [Q7_W-1:0]    r_qm;
    logic [Q7_W-1:0]    r_qo;
    logic [SUM_W-1:0]   r_sm;
    logic [SUM_W-1:0]   r_so;
    logic [MONTH_W-1:0] r_m;
    logic [DAY_W-1:0]   r_d;
    logic [HOUR_W-1:0]  r_h;

    logic [2:0]         n_wm;
    logic [2:0]         n_wo;
    logic [DAY_W-1:0]   n_lms;
    logic [DAY_W-1:0]   n_los;

    assign n_pm = 30'(i_s2.sum_mar) * 30'(DIV7_MUL);
    assign n_po = 30'(i_s2.sum_oct) * 30'(DIV7_MUL);

    always_ff @(posedge i_clk) begin
        r_qm <= n_pm[DIV7_SHIFT +: Q7_W];
        r_qo <= n_po[DIV7_SHIFT +: Q7_W];
        r_sm <= i_s2.sum_mar;
        r_so <= i_s2.sum_oct;
        r_m  <= i_s2.month;
        r_d  <= i_s2.day;
        r_h  <= i_s2.hour;
    end

    always_comb begin
        n_wm  = 3'(r_sm - SUM_W'(r_qm) * SUM_W'(7));
        n_wo  = 3'(r_so - SUM_W'(r_qo) * SUM_W'(7));
        n_lms = DAY_W'(31) - DAY_W'(n_wm);
        n_los = DAY_W'(31) - DAY_W'(n_wo);
        priority if (r_m < MONTH_MAR) begin
            o_summer = 1'b0;
        end else if (r_m == MONTH_MAR) begin
            o_summer = !((r_d < n_lms) || ((r_d == n_lms) && (r_h < DST_HOUR)));
        end else if (r_m < MONTH_OCT) begin
            o_summer = 1'b1;
        end else if (r_m == MONTH_OCT) begin
            o_summer = (r_d < n_los) || ((r_d == n_los) && (r_h < DST_HOUR));
        end else begin
            o_summer = 1'b0;
        end
    end

endmodule

### rtl/core/utc_to_local_date_with_dst_top.sv
// top level: utc date and hour to local date with eu summer time flag
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------
//  input    | start / busy       | i_word  (t_utc_word)
//  result   | o_strobe           | o_word  (t_local_word)
//  config   | i_cfg_we           | i_cfg_data (hour offset)
//
//  one word per cycle, result strobed from the output register of the last stage
//  four register stages: hour and divide by 100, leap and sums,
//  date carry and divide by 7, weekday compare and output register
//  busy stays low; the receiver cannot stall, so the pipe never holds
//  synchronous reset clears the valid bits and the hour offset
module utc_to_local_date_with_dst_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  utcl_pkg::t_utc_word   i_word,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_data,
    output logic                  o_strobe,
    output utcl_pkg::t_local_word o_word
);
    import utcl_pkg::*;

    logic        r_offset;
    logic [4:0]  r_hour_offset;
    t_s2         s2;
    t_date       date3;
    logic        summer3;
    logic        r_v3;
    logic        r_v4;
    t_local_word r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_offset <= 5'd0;
        end else if (i_cfg_we) begin
            r_hour_offset <= i_cfg_data;
        end
    end

    assign r_offset = 1'b0;
    assign busy     = r_offset;

    utcl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (start && !busy),
        .i_word        (i_word),
        .i_hour_offset (r_hour_offset),
        .o_s2          (s2)
    );

    utcl_date u_date (
        .i_clk  (i_clk),
        .i_s2   (s2),
        .o_date (date3)
    );

    utcl_dst u_dst (
        .i_clk    (i_clk),
        .i_s2     (s2),
        .o_summer (summer3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= s2.valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.local_year  <= date3.year;
        r_word.local_month <= date3.month;
        r_word.local_day   <= date3.day;
        r_word.local_hour  <= date3.hour;
        r_word.summer_time <= summer3;
    end

    assign o_strobe = r_v4;
    assign o_word   = r_word;

endmodule

### rtl/core/utcl_chk.sv
// port level checks for the utc to local date pipeline
module utcl_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input utcl_pkg::t_utc_word   i_word,
    input logic                  o_strobe,
    input utcl_pkg::t_local_word o_word
);
    import utcl_pkg::*;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted word gave no result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##4 !o_strobe)
        else $error("result without an accepted word");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");

    a_winter_months: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !busy, 4) && ($past(i_word.utc_month, 4) < MONTH_MAR))
        |-> !o_word.summer_time)
        else $error("summer time flagged before march");

endmodule

bind utc_to_local_date_with_dst_top utcl_chk u_chk (.*);

### tb/utc_to_local_date_with_dst_top_test.sv
// testbench for the utc to local date converter with eu summer time flag
module utc_to_local_date_with_dst_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utcl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_utc_word   i_word     = '0;
    logic        i_cfg_we   = 1'b0;
    logic [4:0]  i_cfg_data = '0;
    logic        o_strobe;
    t_local_word o_word;

    t_local_word pending_local[$];
    int unsigned offset_hours   = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    utc_to_local_date_with_dst_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_word     (o_word)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            default:               return is_leap(y) ? 29 : 28;
        endcase
    endfunction

    // 0 is sunday
    function automatic int unsigned day_of_week(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        int unsigned a1;
        int unsigned a2;
        int unsigned a3;
        a1 = (14 - m) / 12;
        a2 = y - a1;
        a3 = m + 12 * a1 - 2;
        return (d + a2 + a2 / 4 - a2 / 100 + a2 / 400 + (31 * a3) / 12) % 7;
    endfunction

    function automatic bit summer_active(input int unsigned y, input int unsigned m,
                                         input int unsigned d, input int unsigned h);
        int unsigned mar_sun;
        int unsigned oct_sun;
        mar_sun = 31 - day_of_week(y, MONTH_MAR, 31);
        oct_sun = 31 - day_of_week(y, MONTH_OCT, 31);
        if (m < MONTH_MAR) return 1'b0;
        if (m == MONTH_MAR) return (d > mar_sun) || (d == mar_sun && h >= DST_HOUR);
        if (m < MONTH_OCT) return 1'b1;
        if (m == MONTH_OCT) return (d < oct_sun) || (d == oct_sun && h < DST_HOUR);
        return 1'b0;
    endfunction

    function automatic t_local_word local_time_of(input t_utc_word w);
        t_local_word r;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned h;
        y = w.utc_year;
        m = w.utc_month;
        d = w.utc_day;
        h = w.utc_hour;
        h = h + offset_hours;
        if (h > 23) begin
            h = h % 24;
            d = d + 1;
            if (d > days_in_month(y, m)) begin
                d = 1;
                m = m + 1;
                if (m > MONTH_DEC) begin
                    m = MONTH_JAN;
                    y = y + 1;
                end
            end
        end
        r.local_year  = y[YEAR_W-1:0];
        r.local_month = m[MONTH_W-1:0];
        r.local_day   = d[DAY_W-1:0];
        r.local_hour  = h[HOUR_W-1:0];
        r.summer_time = summer_active(w.utc_year, w.utc_month, w.utc_day, w.utc_hour);
        return r;
    endfunction

    function automatic t_utc_word make_utc(input int unsigned y, input int unsigned m,
                                           input int unsigned d, input int unsigned h);
        t_utc_word w;
        w.utc_year  = y[YEAR_W-1:0];
        w.utc_month = m[MONTH_W-1:0];
        w.utc_day   = d[DAY_W-1:0];
        w.utc_hour  = h[HOUR_W-1:0];
        return w;
    endfunction

    function automatic t_utc_word random_utc(input bit full_range);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned h;
        int unsigned last_sun;
        if (full_range)
            return make_utc($urandom_range(0, 16383), $urandom_range(0, 15),
                            $urandom_range(0, 31), $urandom_range(0, 31));
        y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 5))
            0, 1: d = days_in_month(y, m) - $urandom_range(0, 1);
            2: begin
                // around the switch sundays
                m = (m < 7) ? MONTH_MAR : MONTH_OCT;
                last_sun = 31 - day_of_week(y, m, 31);
                d = last_sun - 1 + $urandom_range(0, (last_sun < 31) ? 2 : 1);
            end
            default: d = $urandom_range(1, days_in_month(y, m));
        endcase
        case ($urandom_range(0, 3))
            0:       h = $urandom_range(20, 23);
            1:       h = $urandom_range(0, 1);
            default: h = $urandom_range(0, 23);
        endcase
        return make_utc(y, m, d, h);
    endfunction

    task automatic note_mismatch(input string what, input t_local_word want,
                                 input t_local_word got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %0d-%0d-%0d h%0d dst%0d, got %0d-%0d-%0d h%0d dst%0d",
                     $time, what, want.local_year, want.local_month, want.local_day,
                     want.local_hour, want.summer_time, got.local_year, got.local_month,
                     got.local_day, got.local_hour, got.summer_time);
    endtask

    always @(posedge i_clk) begin
        t_local_word want;
        string bad;
        if (i_rst_n && o_strobe) begin
            if (pending_local.size() == 0) begin
                note_mismatch("unexpected word", '0, o_word);
            end else begin
                want = pending_local.pop_front();
                bad = "";
                if (o_word.local_year !== want.local_year) bad = {bad, " year"};
                if (o_word.local_month !== want.local_month) bad = {bad, " month"};
                if (o_word.local_day !== want.local_day) bad = {bad, " day"};
                if (o_word.local_hour !== want.local_hour) bad = {bad, " hour"};
                if (o_word.summer_time !== want.summer_time) bad = {bad, " summer_time"};
                if (bad != "") note_mismatch({"mismatch in", bad}, want, o_word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // leaves start high so a following word goes out back to back
    task automatic send_utc(input t_utc_word w);
        start  <= 1'b1;
        i_word <= w;
        do @(posedge i_clk); while (busy);
        pending_local.push_back(local_time_of(w));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pending_local.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [4:0] value);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        offset_hours = value;
    endtask

    task automatic send_dst_edges(input int unsigned y);
        int unsigned mar_sun;
        int unsigned oct_sun;
        mar_sun = 31 - day_of_week(y, MONTH_MAR, 31);
        oct_sun = 31 - day_of_week(y, MONTH_OCT, 31);
        send_utc(make_utc(y, MONTH_MAR, mar_sun - 1, 23));
        send_utc(make_utc(y, MONTH_MAR, mar_sun, 0));
        send_utc(make_utc(y, MONTH_MAR, mar_sun, 1));
        send_utc(make_utc(y, MONTH_OCT, oct_sun - 1, 23));
        send_utc(make_utc(y, MONTH_OCT, oct_sun, 0));
        send_utc(make_utc(y, MONTH_OCT, oct_sun, 1));
    endtask

    task automatic run_batch(input int n, input bit full_range, input bit allow_idle);
        int gap_odds;
        gap_odds = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) gap_odds = allow_idle ? $urandom_range(0, 3) : 0;
            send_utc(random_utc(full_range));
            if (gap_odds != 0 && $urandom_range(1, 8) <= gap_odds)
                idle_cycles($urandom_range(1, 17));
        end
    endtask

    task automatic test_reset_offset();
        send_utc(make_utc(1, MONTH_JAN, 1, 0));
        send_utc(make_utc(9999, MONTH_DEC, 31, 23));
        send_dst_edges(2024);
    endtask

    task automatic test_date_carry();
        write_offset(5'd23);
        send_utc(make_utc(2023, 2, 28, 1));
        send_utc(make_utc(2024, 2, 28, 1));
        send_utc(make_utc(2024, 2, 29, 1));
        send_utc(make_utc(1900, 2, 28, 1));
        send_utc(make_utc(2000, 2, 28, 1));
        send_utc(make_utc(2023, 4, 30, 5));
        send_utc(make_utc(2023, MONTH_DEC, 31, 23));
        send_utc(make_utc(9999, MONTH_DEC, 31, 1));
        send_utc(make_utc(2023, MONTH_JAN, 31, 0));
        // days and months outside the calendar, then the highest and lowest year
        send_utc(make_utc(2023, 2, 31, 1));
        send_utc(make_utc(2023, 6, 0, 1));
        send_utc(make_utc(2023, 0, 28, 1));
        send_utc(make_utc(2023, 15, 28, 1));
        send_utc(make_utc(16383, MONTH_DEC, 31, 1));
        send_utc(make_utc(0, 2, 28, 1));
    endtask

    task automatic test_wide_offset();
        write_offset(5'd31);
        send_utc(make_utc(2023, 7, 15, 31));
        send_utc(make_utc(16383, 13, 31, 17));
        send_utc(make_utc(2023, MONTH_OCT, 31, 0));
    endtask

    task automatic test_random_dates();
        write_offset(5'd1);
        run_batch(130, 1'b0, 1'b1);
        write_offset(5'd23);
        run_batch(130, 1'b0, 1'b1);
        write_offset(5'd0);
        run_batch(130, 1'b0, 1'b1);
        write_offset(5'($urandom_range(2, 22)));
        run_batch(130, 1'b0, 1'b1);
        write_offset(5'd31);
        run_batch(130, 1'b0, 1'b1);
    endtask

    task automatic test_field_noise();
        write_offset(5'($urandom_range(0, 31)));
        run_batch(150, 1'b1, 1'b1);
    endtask

    task automatic test_steady_stream();
        write_offset(5'($urandom_range(0, 23)));
        run_batch(200, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_offset();
        test_date_carry();
        test_wide_offset();
        test_random_dates();
        test_field_noise();
        test_steady_stream();
        start <= 1'b0;
        while (pending_local.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/utcl_pkg.sv
rtl/core/utcl_front.sv
rtl/core/utcl_date.sv
rtl/core/utcl_dst.sv
rtl/core/utc_to_local_date_with_dst_top.sv
rtl/core/utcl_chk.sv
tb/utc_to_local_date_with_dst_top_test.sv
